>>> sv/tss_pkg.sv
// Shared types, codes and defaults for the three-stack shared pool block.
package tss_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_POOL_DEPTH = 64;
	localparam int DEF_NUM_STACKS = 3;
	localparam int DEF_DATA_WIDTH = 32;

	// Fixed payload widths
	localparam int VALUE_W = 32;
	localparam int SEL_W   = 2;
	localparam int FLAGS_W = 3;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	typedef struct packed {
		op_t                       operation;
		logic [SEL_W-1:0]          stack_select;
		logic signed [VALUE_W-1:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] pop_value;
		status_t                   status;
		logic [FLAGS_W-1:0]        empty_flags;
	} res_t;

endpackage

>>> sv/tss_cmd_if.sv
// Command channel: valid/ready handshake carrying one push or pop beat.
interface tss_cmd_if;
	import tss_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic [SEL_W-1:0]          stack_select;
	logic signed [VALUE_W-1:0] push_value;

	modport source (output valid, operation, stack_select, push_value, input ready);
	modport sink   (input valid, operation, stack_select, push_value, output ready);

endinterface

>>> sv/tss_rsp_if.sv
// Result channel: valid/ready handshake carrying one result beat.
interface tss_rsp_if;
	import tss_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] pop_value;
	logic [1:0]                status;
	logic [FLAGS_W-1:0]        empty_flags;

	modport source (output valid, pop_value, status, empty_flags, input ready);
	modport sink   (input valid, pop_value, status, empty_flags, output ready);

endinterface

>>> sv/tss_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module tss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/tss_core.sv
// Stack heads, free list, fill count and the entry pool, with the push/pop update logic.
module tss_core #(
	parameter int POOL_DEPTH = tss_pkg::DEF_POOL_DEPTH,
	parameter int NUM_STACKS = tss_pkg::DEF_NUM_STACKS,
	parameter int DATA_WIDTH = tss_pkg::DEF_DATA_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  tss_pkg::cmd_t cmd,
	output tss_pkg::res_t res
);
	import tss_pkg::*;

	localparam int LINK_W = $clog2(POOL_DEPTH + 1);
	localparam int ADDR_W = $clog2(POOL_DEPTH);
	localparam int ENT_W  = DATA_WIDTH + LINK_W;

	typedef logic [LINK_W-1:0]     link_t;
	typedef logic [DATA_WIDTH-1:0] word_t;

	localparam link_t NULL_LINK = LINK_W'(POOL_DEPTH);
	localparam link_t ONE_LINK  = LINK_W'(1);

	// Architectural state
	link_t                 head_q [NUM_STACKS];
	link_t                 free_head_q;
	link_t                 fill_q;

	// Cached top entry of each stack and link of the free-list head
	word_t                 top_data_q [NUM_STACKS];
	link_t                 top_link_q [NUM_STACKS];
	logic [NUM_STACKS-1:0] top_pend_q;
	link_t                 free_link_q;
	logic                  free_pend_q;

	// Next-state values
	link_t                 head_d [NUM_STACKS];
	link_t                 free_head_d;
	link_t                 fill_d;
	word_t                 top_data_d [NUM_STACKS];
	link_t                 top_link_d [NUM_STACKS];
	logic [NUM_STACKS-1:0] top_pend_d;
	link_t                 free_link_d;
	logic                  free_pend_d;

	// Cache views with the read-data bypass applied
	word_t                 top_data_eff [NUM_STACKS];
	link_t                 top_link_eff [NUM_STACKS];
	link_t                 free_link_eff;

	// Pool RAM ports
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [ENT_W-1:0]      ram_wdata;
	logic                  ram_re;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [ENT_W-1:0]      ram_rdata;
	word_t                 rd_data;
	link_t                 rd_link;

	// Decode and selection
	logic [NUM_STACKS-1:0] hit;
	logic                  sel_ok;
	link_t                 sel_head;
	word_t                 sel_data;
	link_t                 sel_link;
	logic                  from_free;
	logic                  from_fill;
	link_t                 slot;
	word_t                 word_in;
	logic [63:0]           pv_ext;
	logic signed [63:0]    pd_ext;
	status_t               status;
	logic [NUM_STACKS+FLAGS_W-1:0] empty_all;

	tss_ram #(
		.WIDTH (ENT_W),
		.DEPTH (POOL_DEPTH)
	) u_pool (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_data = ram_rdata[ENT_W-1:LINK_W];
	assign rd_link = ram_rdata[LINK_W-1:0];

	// Take last cycle's prefetch straight from the RAM output
	always_comb begin
		for (int k = 0; k < NUM_STACKS; k++) begin
			top_data_eff[k] = top_pend_q[k] ? rd_data : top_data_q[k];
			top_link_eff[k] = top_pend_q[k] ? rd_link : top_link_q[k];
		end
		free_link_eff = free_pend_q ? rd_link : free_link_q;
	end

	// Decode the stack number and pick out that stack's head and top entry
	always_comb begin
		sel_head = '0;
		sel_data = '0;
		sel_link = '0;
		for (int k = 0; k < NUM_STACKS; k++) begin
			hit[k] = (int'(cmd.stack_select) == k);
			if (hit[k]) begin
				sel_head |= head_q[k];
				sel_data |= top_data_eff[k];
				sel_link |= top_link_eff[k];
			end
		end
		sel_ok = |hit;
	end

	// Word conversions between the 32-bit port and the stored width
	assign pv_ext  = 64'(unsigned'(cmd.push_value));
	assign word_in = pv_ext[DATA_WIDTH-1:0];
	assign pd_ext  = 64'(signed'(sel_data));

	// Slot for a push: free-list head first, then the next unused entry
	assign from_free = (free_head_q < NULL_LINK);
	assign from_fill = !from_free && (fill_q < NULL_LINK);
	assign slot      = from_free ? free_head_q : fill_q;

	// Outcome of the beat
	always_comb begin
		if (!sel_ok) begin
			status = ST_BAD;
		end else if (cmd.operation == OP_PUSH) begin
			status = (from_free || from_fill) ? ST_OK : ST_FULL;
		end else begin
			status = (sel_head < NULL_LINK) ? ST_OK : ST_EMPTY;
		end
	end

	// Next state, pool write and prefetch of the entry that becomes cached
	always_comb begin
		head_d      = head_q;
		top_data_d  = top_data_eff;
		top_link_d  = top_link_eff;
		top_pend_d  = '0;
		free_head_d = free_head_q;
		free_link_d = free_link_eff;
		free_pend_d = 1'b0;
		fill_d      = fill_q;
		ram_we      = 1'b0;
		ram_waddr   = '0;
		ram_wdata   = '0;
		ram_re      = 1'b0;
		ram_raddr   = '0;

		if (go && status == ST_OK) begin
			if (cmd.operation == OP_PUSH) begin
				ram_we    = 1'b1;
				ram_waddr = slot[ADDR_W-1:0];
				ram_wdata = {word_in, sel_head};
				for (int k = 0; k < NUM_STACKS; k++) begin
					if (hit[k]) begin
						head_d[k]     = slot;
						top_data_d[k] = word_in;
						top_link_d[k] = sel_head;
					end
				end
				if (from_free) begin
					free_head_d = free_link_eff;
					if (free_link_eff < NULL_LINK) begin
						ram_re      = 1'b1;
						ram_raddr   = free_link_eff[ADDR_W-1:0];
						free_pend_d = 1'b1;
					end
				end else begin
					fill_d = fill_q + ONE_LINK;
				end
			end else begin
				// Freed entry keeps its word and chains onto the old free head
				ram_we      = 1'b1;
				ram_waddr   = sel_head[ADDR_W-1:0];
				ram_wdata   = {sel_data, free_head_q};
				free_head_d = sel_head;
				free_link_d = free_head_q;
				for (int k = 0; k < NUM_STACKS; k++) begin
					if (hit[k]) begin
						head_d[k] = sel_link;
					end
				end
				if (sel_link < NULL_LINK) begin
					ram_re    = 1'b1;
					ram_raddr = sel_link[ADDR_W-1:0];
					for (int k = 0; k < NUM_STACKS; k++) begin
						if (hit[k]) begin
							top_pend_d[k] = 1'b1;
						end
					end
				end
			end
		end
	end

	// Result of the beat
	always_comb begin
		empty_all = '0;
		for (int k = 0; k < NUM_STACKS; k++) begin
			empty_all[k] = (head_d[k] >= NULL_LINK);
		end
		res.status      = status;
		res.empty_flags = empty_all[FLAGS_W-1:0];
		if (sel_ok && cmd.operation == OP_POP && status == ST_OK) begin
			res.pop_value = pd_ext[VALUE_W-1:0];
		end else begin
			res.pop_value = '1;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_STACKS; k++) begin
				head_q[k] <= NULL_LINK;
			end
			free_head_q <= NULL_LINK;
			fill_q      <= '0;
			top_pend_q  <= '0;
			free_pend_q <= 1'b0;
		end else begin
			head_q      <= head_d;
			free_head_q <= free_head_d;
			fill_q      <= fill_d;
			top_pend_q  <= top_pend_d;
			free_pend_q <= free_pend_d;
		end
	end

	// Cache payload, captured every cycle
	always_ff @(posedge clk) begin
		top_data_q  <= top_data_d;
		top_link_q  <= top_link_d;
		free_link_q <= free_link_d;
	end

endmodule

>>> sv/three_stacks_shared_pool.sv
// Three LIFO stacks sharing one linked pool of entries: top level with input and result registers.
//
// Each command beat is a push or a pop on one of the stacks, and each gives exactly one result
// beat carrying the popped word (-1 unless a pop succeeds), a status code and the empty flag of
// every stack after the operation. The block takes one command per cycle while the result channel
// is not stalled. The command is held in the input register; the update is then done in a single
// pass when the result register is free or being drained, and lands in the result register.
// A stalled result register holds the input register, so up to two beats sit inside the block.
// The pool is one RAM with a registered read port; the top entry of every stack and the link
// of the free-list head are kept in registers and refilled by at most one RAM read per operation,
// which is what allows a beat every cycle when the result channel does not stall. No clearing
// pass is needed after reset: the pool is only read at entries already written.
module three_stacks_shared_pool #(
	parameter int POOL_DEPTH = tss_pkg::DEF_POOL_DEPTH,
	parameter int NUM_STACKS = tss_pkg::DEF_NUM_STACKS,
	parameter int DATA_WIDTH = tss_pkg::DEF_DATA_WIDTH
) (
	input logic        clk,
	input logic        arst_n,
	tss_cmd_if.sink    cmd,
	tss_rsp_if.source  rsp
);
	import tss_pkg::*;

	localparam logic [FLAGS_W-1:0] FLAG_MASK = FLAGS_W'((64'd1 << NUM_STACKS) - 64'd1);

	cmd_t cmd_s1;
	logic valid_s1;
	res_t res_s2;
	logic valid_s2;
	res_t res;
	logic go;
	logic cmd_accept;

	// Advance when the result register is free or being drained
	assign go         = valid_s1 && (!valid_s2 || rsp.ready);
	assign cmd.ready  = !valid_s1 || go;
	assign cmd_accept = cmd.valid && cmd.ready;

	tss_core #(
		.POOL_DEPTH (POOL_DEPTH),
		.NUM_STACKS (NUM_STACKS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.cmd    (cmd_s1),
		.res    (res)
	);

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd_accept || (valid_s1 && !go);
			valid_s2 <= go || (valid_s2 && !rsp.ready);
		end
	end

	// Capture the command beat and the result beat
	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			cmd_s1.operation    <= op_t'(cmd.operation);
			cmd_s1.stack_select <= cmd.stack_select;
			cmd_s1.push_value   <= cmd.push_value;
		end
		if (go) begin
			res_s2 <= res;
		end
	end

	// Drive the result channel
	assign rsp.valid       = valid_s2;
	assign rsp.pop_value   = res_s2.pop_value;
	assign rsp.status      = res_s2.status;
	assign rsp.empty_flags = res_s2.empty_flags;

	// An advancing beat always lands in the result register
	a_go_lands: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> valid_s2)
		else $error("advancing beat did not reach the result register");

	// A stack number beyond the last stack is reported as such
	a_bad_stack: assert property (@(posedge clk) disable iff (!arst_n)
		(go && int'(cmd_s1.stack_select) >= NUM_STACKS) |=> (res_s2.status == ST_BAD))
		else $error("bad stack number not flagged");

	// Any failed operation returns -1
	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.status != ST_OK) |-> (res_s2.pop_value == '1))
		else $error("failed operation returned a word");

	// No empty flag for a stack that does not exist
	a_flag_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((res_s2.empty_flags & ~FLAG_MASK) == '0))
		else $error("empty flag set for a missing stack");

endmodule
